// ===== rtl/tmbc_pkg.sv =====
// ----------------------------------------------------------------------------
// tmbc_pkg
// Shared types and constants for the tile map box collision block.
// ----------------------------------------------------------------------------
package tmbc_pkg;

  // Item commands.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IW = 2;
  localparam logic [CFG_IW-1:0] REG_TILE_SIZE   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_MAP_ROWS    = 2'd1;
  localparam logic [CFG_IW-1:0] REG_MAP_COLUMNS = 2'd2;

  // Field and register widths.
  localparam int unsigned TS_W   = 9;
  localparam int unsigned MAP_W  = 7;
  localparam int unsigned CFG_DW = 9;
  localparam int unsigned PIX_W  = 16;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned ID_W   = 16;

  // Pixel edges plus extents need one extra bit; quotients share that width.
  localparam int unsigned QW  = PIX_W + 1;
  localparam int unsigned DCW = $clog2(QW);

  // Divider lanes: left, right, top and bottom edges.
  localparam int unsigned NLANE   = 4;
  localparam int unsigned LANE_L  = 0;
  localparam int unsigned LANE_R  = 1;
  localparam int unsigned LANE_T  = 2;
  localparam int unsigned LANE_B  = 3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_CLAMP,
    ST_ADDR,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/tile_map_box_collision.sv =====
// ----------------------------------------------------------------------------
// tile_map_box_collision
// Solid-tile map kept in a one-bit memory, with box collision queries that
// divide the box edges into tile indices and scan the covered tiles.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+----------------------------------
//   in_     | input     | in_valid / in_ready  | cmd, tile row/col/id, box edges
//   out_    | output    | out_valid / out_ready| hit
//   cfg_    | input     | cfg_we               | cfg_index, cfg_wdata
//
// A tile write is stored as it is accepted, and writes can arrive in every
// cycle while the block is idle. A query runs a bit-serial division of the
// box edges and then one memory read per tile through the single read port,
// up to and including the first solid tile (or all covered tiles). A box
// that starts beyond the map reads no tile.
// After reset a clearing pass writes every entry, during which no item is
// accepted.
// The result sits in an output register, so new items are accepted while it
// waits; a later query waits at its end until that register is free.
// ----------------------------------------------------------------------------
module tile_map_box_collision #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration port
  input  logic                                cfg_we,
  input  logic [tmbc_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [tmbc_pkg::CFG_DW-1:0]         cfg_wdata,
  // Input items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic [tmbc_pkg::IDX_W-1:0]          in_tile_row,
  input  logic [tmbc_pkg::IDX_W-1:0]          in_tile_col,
  input  logic signed [tmbc_pkg::ID_W-1:0]    in_tile_id,
  input  logic [tmbc_pkg::PIX_W-1:0]          in_box_left,
  input  logic [tmbc_pkg::PIX_W-1:0]          in_box_top,
  input  logic [tmbc_pkg::PIX_W-1:0]          in_box_width,
  input  logic [tmbc_pkg::PIX_W-1:0]          in_box_height,
  // Result items
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_hit
);
  import tmbc_pkg::*;

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // Configuration registers.
  logic [TS_W-1:0]  tile_size_r;
  logic [MAP_W-1:0] map_rows_r;
  logic [MAP_W-1:0] map_cols_r;

  // Control state.
  state_t           state_r, state_nxt;
  logic [AW-1:0]    clr_addr_r;
  logic [DCW-1:0]   div_cnt_r;
  logic             last_issued_r;
  logic             rd_vld_r;
  logic             hit_r;
  logic             out_valid_r;
  logic             out_hit_r;

  // Datapath registers.
  logic [QW-1:0]    dvd_r [NLANE];
  logic [TS_W-1:0]  rem_r [NLANE];
  logic [CIW-1:0]   lt_r, rt_r, col_r;
  logic [RIW-1:0]   tt_r, bt_r, row_r;
  logic [AW-1:0]    addr_r;
  logic [AW-1:0]    row_step_r;
  logic             rd_data_r;

  // Solid flag memory.
  logic             solid_mem [DEPTH];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic             mem_wdata;

  // Combinational helpers.
  logic             in_acc;
  logic             wr_ok;
  logic [31:0]      wr_lin;
  logic [TS_W-1:0]  ts_eff;
  logic [QW-1:0]    rows_last, cols_last;
  logic [QW-1:0]    rt_c, bt_c;
  logic             box_empty;
  logic [TS_W:0]    trial [NLANE];
  logic             q_bit [NLANE];
  logic [TS_W-1:0]  rem_nxt [NLANE];
  logic [31:0]      base_lin;
  logic             issue;
  logic             scan_hit;
  logic             scan_miss;
  logic             out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_free  = !out_valid_r || out_ready;

  // Configuration writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_size_r <= TS_W'(32);
      map_rows_r  <= MAP_W'(64);
      map_cols_r  <= MAP_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TILE_SIZE:   tile_size_r <= cfg_wdata[TS_W-1:0];
        REG_MAP_ROWS:    map_rows_r  <= cfg_wdata[MAP_W-1:0];
        REG_MAP_COLUMNS: map_cols_r  <= cfg_wdata[MAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective tile size and last row and column in use.
  always_comb begin
    ts_eff = (tile_size_r == '0) ? TS_W'(1) : tile_size_r;
    if (map_rows_r == '0) begin
      rows_last = '0;
    end else if (QW'(map_rows_r) > QW'(MAX_ROWS)) begin
      rows_last = QW'(MAX_ROWS - 1);
    end else begin
      rows_last = QW'(map_rows_r) - QW'(1);
    end
    if (map_cols_r == '0) begin
      cols_last = '0;
    end else if (QW'(map_cols_r) > QW'(MAX_COLS)) begin
      cols_last = QW'(MAX_COLS - 1);
    end else begin
      cols_last = QW'(map_cols_r) - QW'(1);
    end
  end

  // Clamp the right and bottom indices and detect a box that covers nothing.
  always_comb begin
    rt_c = (dvd_r[LANE_R] > cols_last) ? cols_last : dvd_r[LANE_R];
    bt_c = (dvd_r[LANE_B] > rows_last) ? rows_last : dvd_r[LANE_B];
    box_empty = (dvd_r[LANE_L] > rt_c) || (dvd_r[LANE_T] > bt_c);
  end

  // One restoring division step per lane and cycle.
  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      trial[i]   = {rem_r[i], dvd_r[i][QW-1]};
      q_bit[i]   = (trial[i] >= {1'b0, ts_eff});
      rem_nxt[i] = q_bit[i] ? TS_W'(trial[i] - {1'b0, ts_eff}) : trial[i][TS_W-1:0];
    end
  end

  // Tile write address and range check, and scan base address.
  always_comb begin
    wr_ok  = (32'(in_tile_row) < 32'(MAX_ROWS)) && (32'(in_tile_col) < 32'(MAX_COLS));
    wr_lin = 32'(in_tile_row) * 32'(MAX_COLS) + 32'(in_tile_col);
    base_lin = 32'(tt_r) * 32'(MAX_COLS) + 32'(lt_r);
  end

  // Memory write port: clearing pass or tile write.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wdata = 1'b0;
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (in_acc && (in_cmd == CMD_WRITE) && wr_ok) begin
      mem_we    = 1'b1;
      mem_waddr = wr_lin[AW-1:0];
      mem_wdata = (in_tile_id > 16'sd0);
    end
  end

  // Memory with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      solid_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= solid_mem[addr_r];
  end

  // Scan status: a read is issued until the last tile, its data checked in the next cycle.
  assign issue     = (state_r == ST_SCAN) && !last_issued_r;
  assign scan_hit  = rd_vld_r && rd_data_r;
  assign scan_miss = last_issued_r && rd_vld_r && !rd_data_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc && (in_cmd == CMD_QUERY)) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt_r == DCW'(QW - 1)) state_nxt = ST_CLAMP;
      end
      ST_CLAMP: begin
        state_nxt = box_empty ? ST_FINISH : ST_ADDR;
      end
      ST_ADDR: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_hit || scan_miss) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r    <= '0;
      div_cnt_r     <= '0;
      last_issued_r <= 1'b0;
      rd_vld_r      <= 1'b0;
      hit_r         <= 1'b0;
      out_valid_r   <= 1'b0;
      out_hit_r     <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (state_r == ST_IDLE) begin
        div_cnt_r <= '0;
      end else if (state_r == ST_DIV) begin
        div_cnt_r <= div_cnt_r + DCW'(1);
      end
      if (state_r == ST_ADDR) begin
        last_issued_r <= 1'b0;
      end else if (issue && (col_r == rt_r) && (row_r == bt_r)) begin
        last_issued_r <= 1'b1;
      end
      if (state_r == ST_CLAMP) begin
        hit_r <= 1'b0;
      end else if ((state_r == ST_SCAN) && scan_hit) begin
        hit_r <= 1'b1;
      end
      // Output register: load at the end of a query, drop once taken.
      if ((state_r == ST_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
        out_hit_r   <= hit_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Divider lanes, tile range and scan address.
  always_ff @(posedge clk) begin
    if (in_acc && (in_cmd == CMD_QUERY)) begin
      dvd_r[LANE_L] <= QW'(in_box_left);
      dvd_r[LANE_R] <= QW'(in_box_left) + QW'(in_box_width);
      dvd_r[LANE_T] <= QW'(in_box_top);
      dvd_r[LANE_B] <= QW'(in_box_top) + QW'(in_box_height);
      for (int i = 0; i < NLANE; i++) begin
        rem_r[i] <= '0;
      end
    end else if (state_r == ST_DIV) begin
      for (int i = 0; i < NLANE; i++) begin
        dvd_r[i] <= {dvd_r[i][QW-2:0], q_bit[i]};
        rem_r[i] <= rem_nxt[i];
      end
    end
    if (state_r == ST_CLAMP) begin
      lt_r <= dvd_r[LANE_L][CIW-1:0];
      rt_r <= rt_c[CIW-1:0];
      tt_r <= dvd_r[LANE_T][RIW-1:0];
      bt_r <= bt_c[RIW-1:0];
    end
    if (state_r == ST_ADDR) begin
      addr_r     <= base_lin[AW-1:0];
      row_step_r <= AW'(32'(MAX_COLS) - (32'(rt_r) - 32'(lt_r)));
      col_r      <= lt_r;
      row_r      <= tt_r;
    end else if (issue) begin
      // Walk along a row, then jump to the start of the next row.
      if (col_r == rt_r) begin
        col_r  <= lt_r;
        row_r  <= row_r + RIW'(1);
        addr_r <= addr_r + row_step_r;
      end else begin
        col_r  <= col_r + CIW'(1);
        addr_r <= addr_r + AW'(1);
      end
    end
  end

endmodule

// ===== rtl/tmbc_checker.sv =====
// ----------------------------------------------------------------------------
// tmbc_checker
// Port-level checks on the tile map box collision block, bound to its top.
// ----------------------------------------------------------------------------
module tmbc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             in_cmd,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_hit
);
  import tmbc_pkg::*;

  // A stalled result item holds its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit))
    else $error("result item changed while stalled");

  // The clearing pass keeps the input closed right after reset.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("input open during clearing pass");

  // A query occupies the block, so the input closes after it.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_QUERY) |=> !in_ready)
    else $error("input stayed open after a query item");

  // A tile write never produces a result item.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_WRITE) && !out_valid |=> !out_valid)
    else $error("result item after a tile write");

  // A result only appears at the end of a query, while the input is closed.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result item appeared while idle");

endmodule

bind tile_map_box_collision tmbc_checker u_tmbc_checker (.*);
